/* rtl/rtcc_pkg.sv */
package rtcc_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned SubsecW = $clog2(TICKS_PER_SECOND + 1);
  localparam logic [SubsecW-1:0] SubsecLast = SubsecW'(TICKS_PER_SECOND - 1);

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } rtcc_op_e;

  typedef struct packed {
    logic [SubsecW-1:0] subsec;
    logic [5:0]         second;
    logic [5:0]         minute;
    logic [4:0]         hour;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [6:0]         year;
    logic [2:0]         weekday;
  } rtcc_time_t;

  localparam rtcc_time_t TimeReset = '{
    subsec:  '0,
    second:  6'd50,
    minute:  6'd59,
    hour:    5'd11,
    day:     5'd20,
    month:   4'd10,
    year:    7'd8,
    weekday: 3'd1
  };

  // Years 51..127 map to 1951..2027 and 0..50 to 2000..2050; of these only
  // 2000 is a century year and it is divisible by 400, so divisibility of the
  // two-digit year by four decides.
  function automatic logic [4:0] month_len(input logic [6:0] year, input logic [3:0] month);
    logic [4:0] len;
    begin
      case (month)
        4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
        4'd4:    len = 5'd30;
        4'd6:    len = 5'd30;
        4'd9:    len = 5'd30;
        4'd11:   len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

/* rtl/rtcc_advance.sv */
module rtcc_advance (
  input  rtcc_pkg::rtcc_time_t cur_i,
  output rtcc_pkg::rtcc_time_t nxt_o,
  output logic                 day_changed_o
);
  import rtcc_pkg::*;

  logic [5:0] next_day;
  logic [3:0] next_month;

  always_comb begin
    nxt_o         = cur_i;
    day_changed_o = 1'b0;
    next_day      = {1'b0, cur_i.day} + 6'd1;
    next_month    = cur_i.month;
    if (cur_i.subsec < SubsecLast) begin
      nxt_o.subsec = cur_i.subsec + SubsecW'(1);
    end else begin
      nxt_o.subsec = '0;
      if (cur_i.second < 6'd59) begin
        nxt_o.second = cur_i.second + 6'd1;
      end else begin
        nxt_o.second = '0;
        if (cur_i.minute < 6'd59) begin
          nxt_o.minute = cur_i.minute + 6'd1;
        end else begin
          nxt_o.minute = '0;
          if (cur_i.hour < 5'd23) begin
            nxt_o.hour = cur_i.hour + 5'd1;
          end else begin
            nxt_o.hour    = '0;
            day_changed_o = 1'b1;
            nxt_o.weekday = (cur_i.weekday >= 3'd6) ? 3'd0 : cur_i.weekday + 3'd1;
            if (next_day > {1'b0, month_len(cur_i.year, cur_i.month)}) begin
              nxt_o.day  = 5'd1;
              next_month = cur_i.month + 4'd1;
            end else begin
              nxt_o.day = next_day[4:0];
            end
            if (next_month > 4'd12) begin
              nxt_o.month = 4'd1;
              nxt_o.year  = cur_i.year + 7'd1;
            end else begin
              nxt_o.month = next_month;
            end
          end
        end
      end
    end
  end

endmodule

/* rtl/tick_driven_rtc_calendar_unit.sv */
// Millisecond-tick real-time clock and calendar.
// Slave channel: one request per accepted beat. tuser selects the kind:
// 0 is a one millisecond tick, 1 loads the date and time from tdata and
// clears the sub-second count.
// Master channel: one result per request, carrying the time and date after
// that request and a flag that is high when a tick rolled into a new day.
// Latency: the result is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver keeps up; the whole carry
// chain from sub-second count to year is combinational between the time
// register and the output register.
// The output register acts as the buffer between the channels: a new request
// is taken while a result waits if the receiver takes it in the same cycle.
// When the receiver stalls with a result pending, tready drops and the result
// holds until taken.
// Reset sets the clock to 11:59:50 on day 20 of month 10, year 8, weekday 1,
// with no result pending.
module tick_driven_rtc_calendar_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // year[6:0] month[10:7] day[15:11] hour[20:16] minute[26:21]
  // second[32:27] weekday[35:33] zero[39:36]
  input  logic [rtcc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // operation[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // now_second[5:0] now_minute[11:6] now_hour[16:12] now_day[21:17]
  // now_month[25:22] now_year[32:26] now_weekday[35:33] day_changed[36]
  // zero[39:37]
  output logic [rtcc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rtcc_pkg::*;

  rtcc_time_t            time_q, time_d, tick_nxt;
  logic                  tick_day_changed;
  logic                  day_changed_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutDataW-1:0]   out_data_q, out_data_d;
  logic                  req_accept;

  rtcc_advance u_advance (
    .cur_i         (time_q),
    .nxt_o         (tick_nxt),
    .day_changed_o (tick_day_changed)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign req_accept      = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (rtcc_op_e'(s_axis_tuser_i) == OP_SET) begin
      time_d.subsec  = '0;
      time_d.year    = s_axis_tdata_i[6:0];
      time_d.month   = s_axis_tdata_i[10:7];
      time_d.day     = s_axis_tdata_i[15:11];
      time_d.hour    = s_axis_tdata_i[20:16];
      time_d.minute  = s_axis_tdata_i[26:21];
      time_d.second  = s_axis_tdata_i[32:27];
      time_d.weekday = s_axis_tdata_i[35:33];
      day_changed_d  = 1'b0;
    end else begin
      time_d        = tick_nxt;
      day_changed_d = tick_day_changed;
    end
    out_data_d  = {3'b000, day_changed_d, time_d.weekday, time_d.year, time_d.month,
                   time_d.day, time_d.hour, time_d.minute, time_d.second};
    out_valid_d = req_accept || (out_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= TimeReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (req_accept) begin
        time_q <= time_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* rtl/rtcc_checker.sv */
module rtcc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [rtcc_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                          s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [rtcc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rtcc_pkg::*;

  logic req_accept;
  assign req_accept = s_axis_tvalid_i && s_axis_tready_o;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> m_axis_tvalid_o)
    else $error("accepted request produced no result");

  a_set_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && (rtcc_op_e'(s_axis_tuser_i) == OP_SET)) |=>
      (m_axis_tdata_o[5:0] == $past(s_axis_tdata_i[32:27])) &&
      (m_axis_tdata_o[11:6] == $past(s_axis_tdata_i[26:21])) &&
      (m_axis_tdata_o[32:26] == $past(s_axis_tdata_i[6:0])) &&
      !m_axis_tdata_o[36])
    else $error("set request not reflected in result");

  a_day_change_midnight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[36]) |->
      (m_axis_tdata_o[16:0] == 17'd0))
    else $error("day change flagged away from midnight");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind tick_driven_rtc_calendar_unit rtcc_checker u_rtcc_checker (.*);
